// ===== rtl/core/ssc_pkg.sv =====
// shared constants, word types and helpers for the sphere contact pipeline
package ssc_pkg;

  localparam int COORD_BITS = 24;
  localparam int POS_W      = 24;
  localparam int EXT_W      = 34;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int RAD_W      = SUM_W + FRAC_SHIFT;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int RSUM_W     = 24;
  localparam int COARSE_W   = ROOT_W - 6;
  localparam int QUO_W      = 16;
  localparam int NUM_W      = MAG_W + 21;
  localparam int NRM_W      = 16;
  localparam logic [QUO_W-1:0] NORMAL_ONE = QUO_W'(16384);

  typedef struct packed {
    logic [15:0]       first_tag;
    logic [15:0]       second_tag;
    logic [POS_W-1:0]  a_pos_x;
    logic [POS_W-1:0]  a_pos_y;
    logic [POS_W-1:0]  a_pos_z;
    logic [POS_W-1:0]  b_pos_x;
    logic [POS_W-1:0]  b_pos_y;
    logic [POS_W-1:0]  b_pos_z;
    logic [22:0]       a_radius;
    logic [22:0]       b_radius;
    logic [15:0]       a_bounce;
    logic [15:0]       b_bounce;
  } pair_t;

  typedef struct packed {
    logic              touching;
    logic [15:0]       out_first_tag;
    logic [15:0]       out_second_tag;
    logic [NRM_W-1:0]  normal_x;
    logic [NRM_W-1:0]  normal_y;
    logic [NRM_W-1:0]  normal_z;
    logic [23:0]       depth;
    logic [15:0]       bounce;
  } contact_t;

  // sideband that rides along the square root
  typedef struct packed {
    logic              live;
    logic [15:0]       first_tag;
    logic [15:0]       second_tag;
    logic [2:0]        neg;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [MAG_W-1:0]  mag_z;
    logic [RSUM_W-1:0] rsum;
    logic [15:0]       bounce;
  } root_side_t;

  // sideband that rides along the dividers
  typedef struct packed {
    logic              touch;
    logic [15:0]       first_tag;
    logic [15:0]       second_tag;
    logic [2:0]        neg;
    logic [23:0]       depth;
    logic [15:0]       bounce;
  } div_side_t;

  // low COORD_BITS of a position as a two's complement value
  function automatic logic signed [EXT_W-1:0] sext_coord(logic [POS_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = EXT_W'(v);
    for (int i = 0; i < EXT_W; i++) begin
      if (i >= COORD_BITS) r[i] = r[COORD_BITS-1];
    end
    return signed'(r);
  endfunction

endpackage

// ===== rtl/core/ssc_if.sv =====
// valid/ready channels for pair words and contact words
interface ssc_pair_if;
  logic          valid;
  logic          ready;
  ssc_pkg::pair_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssc_contact_if;
  logic             valid;
  logic             ready;
  ssc_pkg::contact_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ssc_sqrt.sv =====
// pipelined digit-by-digit square root, one root bit per stage
module ssc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ssc_pkg::RAD_W-1:0]  radicand,
  input  ssc_pkg::root_side_t        in_side,
  output logic                       out_valid,
  output logic [ssc_pkg::ROOT_W-1:0] root,
  output ssc_pkg::root_side_t        out_side
);
  import ssc_pkg::*;

  logic              v    [ROOT_W+1];
  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] rt   [ROOT_W+1];
  logic [RAD_W-1:0]  rad  [ROOT_W+1];
  root_side_t        side [ROOT_W+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign rad[0]  = radicand;
  assign side[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             take;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      shifted = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
      trial   = REM_W'({rt[k], 2'b01});
      take    = shifted >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? shifted - trial : shifted;
        rt[k+1]   <= {rt[k][ROOT_W-2:0], take};
        rad[k+1]  <= {rad[k][RAD_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = side[ROOT_W];
endmodule

// ===== rtl/core/ssc_div.sv =====
// three-lane pipelined restoring divider, one quotient bit per stage
module ssc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ssc_pkg::NUM_W-1:0]  num [3],
  input  logic [ssc_pkg::ROOT_W-1:0] divisor,
  input  ssc_pkg::div_side_t         in_side,
  output logic                       out_valid,
  output logic [ssc_pkg::QUO_W-1:0]  quo [3],
  output ssc_pkg::div_side_t         out_side
);
  import ssc_pkg::*;

  localparam int DREM_W = ROOT_W + 1;

  logic              v    [QUO_W+1];
  logic [ROOT_W-1:0] dv   [QUO_W+1];
  logic [DREM_W-1:0] rem  [QUO_W+1][3];
  logic [QUO_W-1:0]  low  [QUO_W+1][3];
  div_side_t         side [QUO_W+1];

  // quotient is known to fit QUO_W bits, so the top part is already below the divisor
  assign v[0]    = in_valid;
  assign dv[0]   = divisor;
  assign side[0] = in_side;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = DREM_W'(num[l] >> QUO_W);
    assign low[0][l] = num[l][QUO_W-1:0];
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DREM_W-1:0] shifted;
      logic              take;

      always_comb begin
        shifted = {rem[k][l][DREM_W-2:0], low[k][l][QUO_W-1]};
        take    = shifted >= DREM_W'(dv[k]);
      end

      // remainder on top, quotient bits fill in from the bottom as numerator bits leave
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][l] <= take ? shifted - DREM_W'(dv[k]) : shifted;
          low[k+1][l] <= {low[k][l][QUO_W-2:0], take};
        end
      end
    end
  end

  assign out_valid = v[QUO_W];
  assign out_side  = side[QUO_W];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo[l] = low[QUO_W][l];
  end
endmodule

// ===== rtl/core/sphere_sphere_contact_core.sv =====
// top level of the sphere pair contact generator
// Takes one sphere pair word per cycle while the skid buffer is empty, and returns exactly
// one contact word per pair, in order. Three stages form the offset, squares and squared
// distance, 31 stages of a square-root pipeline give one root bit each, one stage forms
// depth and numerators, 16 stages of a three-lane divider give one normal bit each, and one
// stage packs the word into the output register. A two-entry output register and skid
// buffer keep the pipeline moving while a word waits; the pipeline holds only when both are
// full. Pairs that do not touch give an all-zero word. No reset sweep; ready from the first
// cycle after rst.
module sphere_sphere_contact_core (
  input  logic           clk,
  input  logic           rst,
  ssc_pair_if.sink       pair,
  ssc_contact_if.source  contact
);
  import ssc_pkg::*;

  logic en;
  logic skid_v;
  logic out_v;
  contact_t out_w;
  contact_t skid_w;

  assign en         = !skid_v;
  assign pair.ready = en;

  // stage a: offsets and magnitudes
  logic signed [EXT_W:0] dif [3];
  logic [EXT_W:0]        abs_d [3];
  always_comb begin
    dif[0] = (EXT_W+1)'(sext_coord(pair.data.a_pos_x)) - (EXT_W+1)'(sext_coord(pair.data.b_pos_x));
    dif[1] = (EXT_W+1)'(sext_coord(pair.data.a_pos_y)) - (EXT_W+1)'(sext_coord(pair.data.b_pos_y));
    dif[2] = (EXT_W+1)'(sext_coord(pair.data.a_pos_z)) - (EXT_W+1)'(sext_coord(pair.data.b_pos_z));
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = dif[i][EXT_W] ? -dif[i] : dif[i];
    end
  end

  logic              a_v;
  logic [MAG_W-1:0]  a_mag [3];
  logic [2:0]        a_neg;
  logic              a_far;
  logic [15:0]       a_tag1, a_tag2, a_bounce;
  logic [RSUM_W-1:0] a_rsum;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= pair.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= abs_d[i][MAG_W-1:0];
        a_neg[i] <= dif[i][EXT_W];
      end
      a_far    <= (abs_d[0][EXT_W:MAG_W] != '0) || (abs_d[1][EXT_W:MAG_W] != '0) ||
                  (abs_d[2][EXT_W:MAG_W] != '0);
      a_tag1   <= pair.data.first_tag;
      a_tag2   <= pair.data.second_tag;
      a_bounce <= (pair.data.a_bounce > pair.data.b_bounce) ? pair.data.a_bounce
                                                            : pair.data.b_bounce;
      a_rsum   <= RSUM_W'(pair.data.a_radius) + RSUM_W'(pair.data.b_radius);
    end
  end

  // stage b: squares
  logic             b_v;
  logic [SQ_W-1:0]  b_sq [3];
  root_side_t       b_side;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) b_sq[i] <= a_mag[i] * a_mag[i];
      b_side.live       <= !a_far;
      b_side.first_tag  <= a_tag1;
      b_side.second_tag <= a_tag2;
      b_side.neg        <= a_neg;
      b_side.mag_x      <= a_mag[0];
      b_side.mag_y      <= a_mag[1];
      b_side.mag_z      <= a_mag[2];
      b_side.rsum       <= a_rsum;
      b_side.bounce     <= a_bounce;
    end
  end

  // stage c: squared distance
  logic             c_v;
  logic [SUM_W-1:0] c_s;
  root_side_t       c_side;
  root_side_t       c_side_next;
  logic [SUM_W-1:0] s_sum;

  assign s_sum = SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]) + SUM_W'(b_sq[2]);

  // coincident centres give no contact
  always_comb begin
    c_side_next      = b_side;
    c_side_next.live = b_side.live && (s_sum != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s    <= s_sum;
      c_side <= c_side_next;
    end
  end

  // fine distance in Q25.6; the coarse one is its top bits
  logic              r_v;
  logic [ROOT_W-1:0] r_root;
  root_side_t        r_side;

  ssc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .radicand  ({c_s, FRAC_SHIFT'(0)}),
    .in_side   (c_side),
    .out_valid (r_v),
    .root      (r_root),
    .out_side  (r_side)
  );

  // stage d: contact test, depth and divider numerators
  logic [COARSE_W-1:0] coarse;
  logic [ROOT_W-1:0]   half_root;
  logic                d_v;
  logic [NUM_W-1:0]    d_num [3];
  logic [ROOT_W-1:0]   d_div;
  div_side_t           d_side;

  assign coarse    = r_root[ROOT_W-1 -: COARSE_W];
  assign half_root = r_root >> 1;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= r_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num[0]          <= {1'b0, r_side.mag_x, 20'b0} + NUM_W'(half_root);
      d_num[1]          <= {1'b0, r_side.mag_y, 20'b0} + NUM_W'(half_root);
      d_num[2]          <= {1'b0, r_side.mag_z, 20'b0} + NUM_W'(half_root);
      d_div             <= r_root;
      d_side.touch      <= r_side.live && (COARSE_W'(r_side.rsum) > coarse);
      d_side.first_tag  <= r_side.first_tag;
      d_side.second_tag <= r_side.second_tag;
      d_side.neg        <= r_side.neg;
      d_side.depth      <= 24'(COARSE_W'(r_side.rsum) - coarse);
      d_side.bounce     <= r_side.bounce;
    end
  end

  logic             q_v;
  logic [QUO_W-1:0] q [3];
  div_side_t        q_side;

  ssc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_v),
    .num       (d_num),
    .divisor   (d_div),
    .in_side   (d_side),
    .out_valid (q_v),
    .quo       (q),
    .out_side  (q_side)
  );

  // clamp, apply sign and zero a non-contact word
  logic [QUO_W-1:0] nrm [3];
  contact_t         res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = (q[i] > NORMAL_ONE) ? NORMAL_ONE : q[i];
      if (q_side.neg[i]) nrm[i] = -nrm[i];
    end
    res = '0;
    if (q_side.touch) begin
      res.touching       = 1'b1;
      res.out_first_tag  = q_side.first_tag;
      res.out_second_tag = q_side.second_tag;
      res.normal_x       = NRM_W'(nrm[0]);
      res.normal_y       = NRM_W'(nrm[1]);
      res.normal_z       = NRM_W'(nrm[2]);
      res.depth          = q_side.depth;
      res.bounce         = q_side.bounce;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (contact.ready) skid_v <= 1'b0;
    end else if (q_v) begin
      if (!out_v || contact.ready) out_v <= 1'b1;
      else skid_v <= 1'b1;
    end else if (contact.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (contact.ready) out_w <= skid_w;
    end else if (q_v) begin
      if (!out_v || contact.ready) out_w <= res;
      else skid_w <= res;
    end
  end

  assign contact.valid = out_v;
  assign contact.data  = out_w;
endmodule
